>>> rtl/particle_pool_update_macros.svh
// Assertion macros for the particle pool RTL.
// Depends on nothing; included by particle_pool_update, which carries assertions.
`ifndef PARTICLE_POOL_UPDATE_MACROS_SVH
`define PARTICLE_POOL_UPDATE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define PPU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PPU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

>>> rtl/ppu_pkg.sv
// Package for the particle pool: payload structs, constants, operation codes.
// Depends on nothing.
package ppu_pkg;
	localparam int MaxParticles = 64;
	localparam logic [1:0] OP_SPAWN  = 2'd0;
	localparam logic [1:0] OP_ADVANCE = 2'd1;
	localparam logic [1:0] OP_RENDER = 2'd2;
	localparam logic [15:0] DefaultSize = 16'd64;
	localparam logic [15:0] MinRadius = 16'd5;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic [23:0]        lifetime;
		logic [23:0]        delta_time;
		logic [15:0]        spawn_size;
		logic [31:0]        start_color;
		logic [31:0]        end_color;
	} in_item_t;

	typedef struct packed {
		logic               accepted;
		logic [6:0]         live_count_out;
		logic               has_particle;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic [31:0]        out_color;
		logic [15:0]        out_radius;
		logic               last_item;
	} out_item_t;

	// One stored particle, all fields in one memory word.
	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
		logic [31:0]        sc;
		logic [31:0]        ec;
		logic [23:0]        life;
		logic [23:0]        age;
		logic [15:0]        rad;
	} slot_t;
endpackage

>>> rtl/ppu_ram.sv
// Generic single-port-write, one-read-port RAM with registered read data.
// Depends on nothing.
module ppu_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/particle_pool_update.sv
// Particle pool of up to MAX_PARTICLES slots with spawn, advance and render operations. A spawn,
// an advance with nothing to do, a render of an empty pool and any other operation give one
// result beat in the cycle after the input beat is accepted, and the input is ready again once
// that result has been taken. An advance takes each surviving particle through read, read wait,
// age update, three multiply and add pairs for the axes and a write back. An expired particle
// stops after the age update and pulls the last slot in for another visit of the same slot. The
// single result of an advance is loaded into the output register in S_LAST after the last
// particle. A render takes each particle through read and read wait, a 24-step restoring divider
// for the fraction of life used, one shared multiplier for colors, alpha and radius, and a load
// of the output register. That register holds each result until it is taken, which stalls the
// walk. All slot data lives in one RAM read at one address.
// Depends on ppu_pkg, ppu_ram and particle_pool_update_macros.svh.
`include "particle_pool_update_macros.svh"
module particle_pool_update #(
	parameter int MAX_PARTICLES = ppu_pkg::MaxParticles
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ppu_pkg::in_item_t    in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ppu_pkg::out_item_t   out_data
);
	localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int SW = $bits(ppu_pkg::slot_t);
	localparam logic [6:0] MaxCount = 7'(MAX_PARTICLES);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_READ  = 4'd1;
	localparam logic [3:0] S_WAIT  = 4'd2;
	localparam logic [3:0] S_AGE   = 4'd3;
	localparam logic [3:0] S_MUL   = 4'd4;
	localparam logic [3:0] S_ADD   = 4'd5;
	localparam logic [3:0] S_WRITE = 4'd6;
	localparam logic [3:0] S_DIV   = 4'd7;
	localparam logic [3:0] S_RMUL  = 4'd8;
	localparam logic [3:0] S_RACC  = 4'd9;
	localparam logic [3:0] S_EMIT  = 4'd10;
	localparam logic [3:0] S_OUT   = 4'd11;
	localparam logic [3:0] S_LAST  = 4'd12;

	logic [3:0]        state_q;
	logic [6:0]        count_q;
	logic [6:0]        idx_q;
	logic [1:0]        op_q;
	logic [23:0]       dt_q;
	ppu_pkg::slot_t    cur_q;
	logic              fetch_last_q;
	logic [3:0]        step_q;
	logic [4:0]        dcnt_q;
	logic [47:0]       rem_q;
	logic [23:0]       quo_q;
	logic [16:0]       t_q;
	logic [16:0]       r_q;
	logic [31:0]       acc_q [4];
	logic [63:0]       prod_q;
	logic              out_valid_q;
	ppu_pkg::out_item_t out_q;

	logic              we;
	logic [AW-1:0]     waddr;
	ppu_pkg::slot_t    wslot;
	logic [AW-1:0]     raddr;
	logic [SW-1:0]     rdata;

	ppu_ram #(.Width(SW), .Depth(MAX_PARTICLES)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wslot),
		.raddr(raddr), .rdata(rdata)
	);

	// Shared multiplier operands.
	logic signed [32:0] ma;
	logic signed [32:0] mb;
	logic signed [65:0] mp;
	assign mp = ma * mb;

	always_comb begin
		ma = '0;
		mb = '0;
		if (state_q == S_MUL) begin
			mb = {9'd0, dt_q};
			unique case (step_q[1:0])
				2'd0: ma = {cur_q.vx[31], cur_q.vx};
				2'd1: ma = {cur_q.vy[31], cur_q.vy};
				default: ma = {cur_q.vz[31], cur_q.vz};
			endcase
		end else begin
			// Render products: step 0..7 lerp halves, 8 alpha fade, 9 radius.
			priority if (step_q == 4'd9) begin
				ma = {17'd0, cur_q.rad};
				mb = {16'd0, r_q};
			end else if (step_q == 4'd8) begin
				ma = {25'd0, acc_q[3][7:0]};
				mb = {16'd0, r_q};
			end else begin
				ma = step_q[0] ? {25'd0, cur_q.ec[8*(3-step_q[2:1]) +: 8]}
				               : {25'd0, cur_q.sc[8*(3-step_q[2:1]) +: 8]};
				mb = step_q[0] ? {16'd0, t_q} : {16'd0, r_q};
			end
		end
	end

	// Rounded movement and saturated add.
	logic signed [63:0] mv_round;
	logic signed [48:0] mv_sum;
	logic signed [31:0] mv_sat;
	assign mv_round = prod_q + 64'sd32768;
	assign mv_sum = {{17{cur_q.px[31]}}, 32'd0} + 49'sd0 +
		((step_q[1:0] == 2'd0) ? {{17{cur_q.px[31]}}, cur_q.px} :
		 (step_q[1:0] == 2'd1) ? {{17{cur_q.py[31]}}, cur_q.py} :
		                         {{17{cur_q.pz[31]}}, cur_q.pz}) -
		{{17{cur_q.px[31]}}, 32'd0} + {mv_round[63], mv_round[63:16]};
	always_comb begin
		if (mv_sum > 49'sd2147483647) mv_sat = 32'sh7FFFFFFF;
		else if (mv_sum < -49'sd2147483648) mv_sat = 32'sh80000000;
		else mv_sat = mv_sum[31:0];
	end

	logic [24:0] age_sum;
	logic [23:0] age_new;
	assign age_sum = {1'b0, cur_q.age} + {1'b0, dt_q};
	assign age_new = age_sum[24] ? 24'hFFFFFF : age_sum[23:0];

	// Restoring divider step: age<<16 / life, with the divisor aligned eight bits up.
	logic [48:0] dtrial;
	assign dtrial = {rem_q, 1'b0} - {17'd0, cur_q.life, 8'd0};

	logic [6:0] last_idx;
	assign last_idx = count_q - 7'd1;

	always_comb begin
		we = 1'b0;
		waddr = idx_q[AW-1:0];
		wslot = cur_q;
		if (state_q == S_IDLE && in_valid && in_ready && in_data.operation == ppu_pkg::OP_SPAWN
		    && count_q < MaxCount && in_data.lifetime != 24'd0) begin
			we = 1'b1;
			waddr = count_q[AW-1:0];
			wslot.px = in_data.pos_x;
			wslot.py = in_data.pos_y;
			wslot.pz = in_data.pos_z;
			wslot.vx = in_data.vel_x;
			wslot.vy = in_data.vel_y;
			wslot.vz = in_data.vel_z;
			wslot.sc = in_data.start_color;
			wslot.ec = in_data.end_color;
			wslot.life = in_data.lifetime;
			wslot.age = '0;
			wslot.rad = (in_data.spawn_size == 16'd0) ? ppu_pkg::DefaultSize : in_data.spawn_size;
		end else if (state_q == S_WRITE) begin
			we = 1'b1;
		end
	end
	// The count has already dropped when the last slot is fetched, so it names that slot.
	assign raddr = fetch_last_q ? count_q[AW-1:0] : idx_q[AW-1:0];

	assign in_ready = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q <= '0;
			op_q <= '0;
			out_valid_q <= 1'b0;
			fetch_last_q <= 1'b0;
			step_q <= '0;
			dcnt_q <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_EMIT && state_q != S_LAST)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						op_q <= in_data.operation;
						dt_q <= in_data.delta_time;
						idx_q <= '0;
						fetch_last_q <= 1'b0;
						if (in_data.operation == ppu_pkg::OP_SPAWN) begin
							if (count_q < MaxCount && in_data.lifetime != 24'd0) begin
								count_q <= count_q + 7'd1;
								out_q <= {1'b1, count_q + 7'd1, 1'b0, 144'd0, 1'b1};
							end else begin
								out_q <= {1'b0, count_q, 1'b0, 144'd0, 1'b1};
							end
							out_valid_q <= 1'b1;
						end else if ((in_data.operation == ppu_pkg::OP_ADVANCE
						              && in_data.delta_time != 24'd0 && count_q != 7'd0)
						             || (in_data.operation == ppu_pkg::OP_RENDER
						                 && count_q != 7'd0)) begin
							state_q <= S_READ;
						end else begin
							out_q <= {1'b0, count_q, 1'b0, 144'd0, 1'b1};
							out_valid_q <= 1'b1;
						end
					end
				end
				S_READ: state_q <= S_WAIT;
				S_WAIT: begin
					cur_q <= rdata;
					fetch_last_q <= 1'b0;
					step_q <= '0;
					if (op_q == ppu_pkg::OP_ADVANCE) begin
						state_q <= S_AGE;
					end else begin
						rem_q <= {24'd0, rdata[23+16:16]};
						quo_q <= '0;
						dcnt_q <= '0;
						state_q <= S_DIV;
					end
				end
				S_AGE: begin
					cur_q.age <= age_new;
					if (age_new >= cur_q.life) begin
						count_q <= last_idx;
						if (idx_q == last_idx) begin
							state_q <= S_LAST;
						end else begin
							// Pull the last slot into this one, then examine it here.
							fetch_last_q <= 1'b1;
							state_q <= S_READ;
						end
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q <= mp[63:0];
					state_q <= S_ADD;
				end
				S_ADD: begin
					unique case (step_q[1:0])
						2'd0: cur_q.px <= mv_sat;
						2'd1: cur_q.py <= mv_sat;
						default: cur_q.pz <= mv_sat;
					endcase
					if (step_q[1:0] == 2'd2) begin
						state_q <= S_WRITE;
					end else begin
						step_q <= step_q + 4'd1;
						state_q <= S_MUL;
					end
				end
				S_WRITE: begin
					if (idx_q + 7'd1 >= count_q) begin
						state_q <= S_LAST;
					end else begin
						idx_q <= idx_q + 7'd1;
						state_q <= S_READ;
					end
				end
				S_DIV: begin
					if (!dtrial[48]) begin
						rem_q <= dtrial[47:0];
						quo_q <= {quo_q[22:0], 1'b1};
					end else begin
						rem_q <= {rem_q[46:0], 1'b0};
						quo_q <= {quo_q[22:0], 1'b0};
					end
					dcnt_q <= dcnt_q + 5'd1;
					if (dcnt_q == 5'd23) state_q <= S_RMUL;
				end
				S_RMUL: begin
					// The divider leaves its count at 24; the fractions are taken only then.
					if (dcnt_q == 5'd24) begin
						t_q <= (quo_q > 24'd65536) ? 17'd65536 : quo_q[16:0];
						r_q <= 17'd65536 - ((quo_q > 24'd65536) ? 17'd65536 : quo_q[16:0]);
						state_q <= S_RACC;
						step_q <= 4'd15;
					end else begin
						prod_q <= mp[63:0];
						state_q <= S_RACC;
					end
				end
				S_RACC: begin
					priority if (step_q == 4'd15) begin
						step_q <= 4'd0;
						state_q <= S_RMUL;
						acc_q[0] <= '0;
						acc_q[1] <= '0;
						acc_q[2] <= '0;
						acc_q[3] <= '0;
						prod_q <= '0;
						dcnt_q <= '0;
					end else begin
						if (step_q <= 4'd7) begin
							if (step_q[0]) begin
								acc_q[step_q[2:1]] <= 32'((acc_q[step_q[2:1]] + prod_q[31:0]
									+ 32'd32768) >> 16);
							end else begin
								acc_q[step_q[2:1]] <= prod_q[31:0];
							end
						end else if (step_q == 4'd8) begin
							acc_q[3] <= 32'((prod_q[31:0] + 32'd32768) >> 16);
						end else begin
							acc_q[0][31:8] <= acc_q[0][31:8];
							prod_q <= 64'((prod_q[31:0] + 32'd32768) >> 16);
						end
						if (step_q == 4'd9) state_q <= S_EMIT;
						else begin
							step_q <= step_q + 4'd1;
							state_q <= S_RMUL;
						end
					end
				end
				S_EMIT: begin
					if (!out_valid_q || out_ready) begin
						out_q.accepted <= 1'b0;
						out_q.live_count_out <= count_q;
						out_q.has_particle <= 1'b1;
						out_q.out_x <= cur_q.px;
						out_q.out_y <= cur_q.py;
						out_q.out_z <= cur_q.pz;
						out_q.out_color <= {acc_q[0][7:0], acc_q[1][7:0], acc_q[2][7:0],
						                    acc_q[3][7:0]};
						out_q.out_radius <= (prod_q[15:0] < ppu_pkg::MinRadius)
							? ppu_pkg::MinRadius : prod_q[15:0];
						out_q.last_item <= (idx_q + 7'd1 == count_q);
						out_valid_q <= 1'b1;
						if (idx_q + 7'd1 == count_q) begin
							state_q <= S_OUT;
						end else begin
							idx_q <= idx_q + 7'd1;
							state_q <= S_READ;
						end
					end
				end
				S_OUT: state_q <= S_IDLE;
				S_LAST: begin
					if (!out_valid_q || out_ready) begin
						out_q <= {1'b0, count_q, 1'b0, 144'd0, 1'b1};
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`PPU_ASSERT_IMP(a_count_range, 1'b1, count_q <= MaxCount)
	`PPU_ASSERT_IMP(a_ready_idle, in_ready, state_q == S_IDLE && !out_valid_q)
	`PPU_ASSERT_NEXT(a_accept_busy, in_valid && in_ready && in_data.operation == ppu_pkg::OP_RENDER
		&& count_q != 7'd0, !in_ready)
	`PPU_ASSERT_IMP(a_emit_index, state_q == S_EMIT, idx_q < count_q)
endmodule

>>> tb/sv/tb.sv
// Testbench for particle_pool_update: drives spawn, advance, render and idle-code beats and checks
// every result against a predictor of the particle pool kept inside this module.
// Depends on ppu_pkg and the particle_pool_update RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_IDLE = 2'd3;
	localparam int CycleLimit = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	ppu_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	ppu_pkg::out_item_t out_data;

	always #2 clk = ~clk;

	particle_pool_update u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// Predicted pool contents.
	ppu_pkg::slot_t pool [ppu_pkg::MaxParticles];
	int unsigned pool_count = 0;
	ppu_pkg::out_item_t pending_results [$];
	int mismatches = 0;
	int cycles = 0;
	int hold_cycles = 0;

	function automatic logic signed [31:0] move_axis(logic signed [31:0] p,
			logic signed [31:0] v, logic [23:0] dt);
		longint prod;
		longint sum;
		prod = longint'(v) * longint'({8'd0, dt}) + 64'sd32768;
		sum = longint'(p) + (prod >>> 16);
		if (sum > 64'sd2147483647) sum = 64'sd2147483647;
		if (sum < -64'sd2147483648) sum = -64'sd2147483648;
		return sum[31:0];
	endfunction

	function automatic logic [7:0] blend_channel(logic [7:0] s, logic [7:0] e,
			logic [16:0] t, logic [16:0] r);
		logic [63:0] acc;
		acc = 64'(s) * 64'(r) + 64'(e) * 64'(t) + 64'd32768;
		return acc[23:16];
	endfunction

	function automatic ppu_pkg::out_item_t empty_result(logic acc);
		ppu_pkg::out_item_t o;
		o = '0;
		o.accepted = acc;
		o.live_count_out = 7'(pool_count);
		o.last_item = 1'b1;
		return o;
	endfunction

	task automatic predict_pool_op(input ppu_pkg::in_item_t it);
		ppu_pkg::out_item_t o;
		int unsigned i;
		logic [24:0] a;
		logic [63:0] t64, wide;
		logic [16:0] t, r;
		logic [7:0] ca;
		ppu_pkg::slot_t s;
		case (it.operation)
			ppu_pkg::OP_SPAWN: begin
				if (pool_count >= ppu_pkg::MaxParticles || it.lifetime == 0) begin
					pending_results.push_back(empty_result(1'b0));
				end else begin
					s.px = it.pos_x; s.py = it.pos_y; s.pz = it.pos_z;
					s.vx = it.vel_x; s.vy = it.vel_y; s.vz = it.vel_z;
					s.sc = it.start_color; s.ec = it.end_color;
					s.life = it.lifetime; s.age = '0;
					s.rad = it.spawn_size != 0 ? it.spawn_size : ppu_pkg::DefaultSize;
					pool[pool_count] = s;
					pool_count++;
					pending_results.push_back(empty_result(1'b1));
				end
			end
			ppu_pkg::OP_ADVANCE: begin
				i = 0;
				if (it.delta_time != 0) begin
					while (i < pool_count) begin
						a = {1'b0, pool[i].age} + {1'b0, it.delta_time};
						pool[i].age = a[24] ? 24'hFFFFFF : a[23:0];
						if (pool[i].age >= pool[i].life) begin
							// Swap-remove: the last particle is examined in this slot next.
							pool[i] = pool[pool_count - 1];
							pool_count--;
							continue;
						end
						pool[i].px = move_axis(pool[i].px, pool[i].vx, it.delta_time);
						pool[i].py = move_axis(pool[i].py, pool[i].vy, it.delta_time);
						pool[i].pz = move_axis(pool[i].pz, pool[i].vz, it.delta_time);
						i++;
					end
				end
				pending_results.push_back(empty_result(1'b0));
			end
			ppu_pkg::OP_RENDER: begin
				if (pool_count == 0) pending_results.push_back(empty_result(1'b0));
				for (i = 0; i < pool_count; i++) begin
					s = pool[i];
					t64 = {24'd0, s.age, 16'd0} / {40'd0, s.life};
					t = t64 > 64'd65536 ? 17'd65536 : t64[16:0];
					r = 17'd65536 - t;
					o = '0;
					o.live_count_out = 7'(pool_count);
					o.has_particle = 1'b1;
					o.out_x = s.px; o.out_y = s.py; o.out_z = s.pz;
					ca = blend_channel(s.sc[7:0], s.ec[7:0], t, r);
					wide = 64'(ca) * 64'(r) + 64'd32768;
					o.out_color = {blend_channel(s.sc[31:24], s.ec[31:24], t, r),
						blend_channel(s.sc[23:16], s.ec[23:16], t, r),
						blend_channel(s.sc[15:8], s.ec[15:8], t, r), wide[23:16]};
					wide = 64'(s.rad) * 64'(r) + 64'd32768;
					o.out_radius = wide[31:16] < ppu_pkg::MinRadius ? ppu_pkg::MinRadius
						: wide[31:16];
					o.last_item = (i + 1 == pool_count);
					pending_results.push_back(o);
				end
			end
			default: pending_results.push_back(empty_result(1'b0));
		endcase
	endtask

	// Sends one beat and records its predicted results once accepted.
	task automatic send_beat(input ppu_pkg::in_item_t it);
		@(negedge clk);
		in_data <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_pool_op(it);
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic random_gap();
		if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) @(negedge clk);
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic ppu_pkg::in_item_t random_spawn();
		ppu_pkg::in_item_t it;
		it = '0;
		it.operation = ppu_pkg::OP_SPAWN;
		it.pos_x = $urandom; it.pos_y = $urandom; it.pos_z = $urandom;
		case ($urandom_range(0, 2))
			0: begin it.vel_x = $urandom; it.vel_y = $urandom; it.vel_z = $urandom; end
			default: begin
				it.vel_x = $signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000;
				it.vel_y = $signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000;
				it.vel_z = $signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000;
			end
		endcase
		it.lifetime = $urandom_range(0, 7) == 0 ? 24'($urandom) : 24'($urandom_range(1, 24'h40000));
		if ($urandom_range(0, 15) == 0) it.lifetime = '0;
		it.spawn_size = $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom);
		it.start_color = $urandom; it.end_color = $urandom;
		it.delta_time = $urandom;
		return it;
	endfunction

	function automatic ppu_pkg::in_item_t op_beat(logic [1:0] op, logic [23:0] dt);
		ppu_pkg::in_item_t it;
		it = '0;
		it.operation = op;
		it.delta_time = dt;
		it.pos_x = $urandom; it.lifetime = $urandom; it.end_color = $urandom;
		return it;
	endfunction

	task automatic test_directed();
		ppu_pkg::in_item_t it;
		send_beat(op_beat(ppu_pkg::OP_RENDER, 24'd0));
		send_beat(op_beat(ppu_pkg::OP_ADVANCE, 24'h010000));
		send_beat(op_beat(OP_IDLE, 24'hFFFFFF));
		it = random_spawn(); it.lifetime = '0; send_beat(it);
		// Extremes: saturating positions, maximal velocities, zero size.
		it = random_spawn();
		it.pos_x = 32'sh7FFFFFFF; it.pos_y = 32'sh80000000; it.pos_z = '0;
		it.vel_x = 32'sh7FFFFFFF; it.vel_y = 32'sh80000000; it.vel_z = -32'sd1;
		it.lifetime = 24'hFFFFFF; it.spawn_size = '0;
		it.start_color = 32'hFFFFFFFF; it.end_color = 32'h0;
		send_beat(it);
		it = random_spawn();
		it.lifetime = 24'd1; it.spawn_size = 16'hFFFF;
		it.start_color = 32'h0; it.end_color = 32'hFFFFFFFF;
		send_beat(it);
		it = random_spawn(); it.lifetime = 24'h020000; send_beat(it);
		send_beat(op_beat(ppu_pkg::OP_RENDER, 24'd0));
		send_beat(op_beat(ppu_pkg::OP_ADVANCE, 24'd0));
		send_beat(op_beat(ppu_pkg::OP_ADVANCE, 24'h008000));
		send_beat(op_beat(ppu_pkg::OP_RENDER, 24'd0));
		send_beat(op_beat(ppu_pkg::OP_ADVANCE, 24'hFFFFFF));
		send_beat(op_beat(ppu_pkg::OP_RENDER, 24'd0));
		wait_drained();
	endtask

	// Fills the pool past capacity; the receiver holds off at the start, so the first result waits.
	task automatic test_full_pool();
		int k;
		hold_cycles = 600;
		for (k = 0; k < 66; k++) send_beat(random_spawn());
		send_beat(op_beat(ppu_pkg::OP_RENDER, 24'd0));
		send_beat(op_beat(ppu_pkg::OP_ADVANCE, 24'h000100));
		send_beat(op_beat(ppu_pkg::OP_RENDER, 24'd0));
		wait_drained();
		send_beat(op_beat(ppu_pkg::OP_ADVANCE, 24'hFFFFFF));
		wait_drained();
	endtask

	task automatic test_random_mix();
		int k, n;
		for (k = 0; k < 130; k++) begin
			n = $urandom_range(0, 9);
			if (n < 5) send_beat(random_spawn());
			else if (n < 8) send_beat(op_beat(ppu_pkg::OP_ADVANCE,
				$urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(0, 24'h8000))));
			else if (n < 9 || pool_count > 20)
				send_beat(op_beat(ppu_pkg::OP_RENDER, 24'($urandom)));
			else send_beat(op_beat(OP_IDLE, 24'($urandom)));
			random_gap();
		end
		wait_drained();
	endtask

	// Receiver: random stall pattern with always-ready phases, plus a long hold-off when requested.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else if (cycles[9]) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		ppu_pkg::out_item_t exp_res;
		cycles <= cycles + 1;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", out_data);
			end else begin
				exp_res = pending_results.pop_front();
				if (out_data !== exp_res) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected %p", exp_res);
						$display("          actual   %p", out_data);
					end
				end
			end
		end
		if (cycles >= CycleLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_full_pool();
		test_random_mix();
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
